/* rtl/core/ndq_pkg.sv */
`timescale 1ns / 1ps

package ndq_pkg;

   // Fixed field widths
   localparam int IDX_W      = 9;
   localparam int SIZE_W     = 10;
   localparam int COS_W      = 30;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes (paddr[2])
   localparam logic REG_TABLE_SIZE = 1'b0;
   localparam logic REG_MIN_COSINE = 1'b1;

   // Item actions
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 10'd500;

   typedef struct packed {
      logic load;      // write the table entry carried by the accepted item
      logic start;     // capture the query and reset the running best
      logic issue;     // read one table entry into the dot product pipeline
      logic take;      // move the finished result into the output register
      logic is_query;  // the finished transaction was a query
   } cmd_type;

   typedef struct packed {
      logic busy;      // dot product pipeline still holds entries
   } status_type;

endpackage

/* rtl/core/nearest_direction_quantizer.sv */
`timescale 1ns / 1ps

// Nearest direction quantizer.
// Request channel (req_valid / req_stall): each transaction is either a load,
// which writes req_dir_x/y/z into table slot req_entry_index, or a query,
// which searches the first n = min(table_size, TABLE_DEPTH) table entries for
// the largest dot product with the query that is strictly above min_cosine.
// Response channel (rsp_valid / rsp_stall): one transaction per request,
// carrying rsp_best_index and rsp_found; loads and misses return 0 / 0.
// A query streams its n table entries, one per cycle, from the single table
// read port into a read / multiply / add / compare pipeline. A new request is
// taken once the previous result has entered the output register, so the
// block works on one transaction at a time.
// Configuration: APB-style, table_size at 0x0, min_cosine at 0x4; write only
// while the block is idle. Table contents are undefined after reset; query only
// over slots that were loaded.
// Reset (synchronous, active high) clears the control state and sets
// table_size to 500 and min_cosine to 0; the table is not cleared.
// While rsp_stall is high the output register holds its result; one further
// request is still taken and worked on behind it.
module nearest_direction_quantizer #(
   parameter int TABLE_DEPTH     = 512,
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [ndq_pkg::IDX_W-1:0]           req_entry_index,
   input  logic signed [COMPONENT_WIDTH-1:0]   req_dir_x,
   input  logic signed [COMPONENT_WIDTH-1:0]   req_dir_y,
   input  logic signed [COMPONENT_WIDTH-1:0]   req_dir_z,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ndq_pkg::IDX_W-1:0]           rsp_best_index,
   output logic                                rsp_found,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ndq_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [ndq_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [ndq_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [ndq_pkg::SIZE_W-1:0]        table_size_ff, table_size_in;
   logic signed [ndq_pkg::COS_W-1:0]  min_cosine_ff, min_cosine_in;
   logic                              csr_write;
   ndq_pkg::cmd_type                  cmd;
   ndq_pkg::status_type               status;
   logic [AW-1:0]                     issue_addr;

   // Configuration registers: decode on the word address bit only
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      table_size_in = table_size_ff;
      min_cosine_in = min_cosine_ff;
      if (csr_write) begin
         unique case (paddr[2])
            ndq_pkg::REG_TABLE_SIZE: table_size_in = pwdata[ndq_pkg::SIZE_W-1:0];
            ndq_pkg::REG_MIN_COSINE: min_cosine_in = pwdata[ndq_pkg::COS_W-1:0];
            default:                 table_size_in = table_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= ndq_pkg::TABLE_SIZE_RESET;
         min_cosine_ff <= '0;
      end else begin
         table_size_ff <= table_size_in;
         min_cosine_ff <= min_cosine_in;
      end
   end

   // Read back: table_size zero-extended, min_cosine sign-extended
   always_comb begin
      unique case (paddr[2])
         ndq_pkg::REG_TABLE_SIZE: prdata = ndq_pkg::CSR_DATA_W'(table_size_ff);
         ndq_pkg::REG_MIN_COSINE: prdata = ndq_pkg::CSR_DATA_W'(min_cosine_ff);
         default:                 prdata = '0;
      endcase
   end

   // Sequencer: accepts transactions, steps the table scan, loads the result
   ndq_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .table_size (table_size_ff),
      .status     (status),
      .cmd        (cmd),
      .issue_addr (issue_addr)
   );

   // Table memory, dot product pipeline, running best and output register
   ndq_datapath #(
      .TABLE_DEPTH     (TABLE_DEPTH),
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .issue_addr      (issue_addr),
      .req_entry_index (req_entry_index),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_dir_z       (req_dir_z),
      .min_cosine      (min_cosine_ff),
      .status          (status),
      .rsp_best_index  (rsp_best_index),
      .rsp_found       (rsp_found)
   );

   // A miss or a load always reports index zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_best_index == '0))
      else $error("nonzero index without a match");

   // Once a transaction is taken the block stops taking more until it is done
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a transaction is in progress");

   // A fresh result only follows a cycle in which the sequencer was busy
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a transaction in progress");

endmodule

/* rtl/core/ndq_ctrl.sv */
`timescale 1ns / 1ps

module ndq_ctrl #(
   parameter int TABLE_DEPTH = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_action,
   output logic                            req_stall,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [ndq_pkg::SIZE_W-1:0]      table_size,
   input  ndq_pkg::status_type             status,
   output ndq_pkg::cmd_type                cmd,
   output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] issue_addr
);

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic             is_query_ff, is_query_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] n_sat;
   logic             accept;
   logic             out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign issue_addr = cnt_ff[AW-1:0];

   // Clamp the search length to the table depth
   assign n_sat = (32'(table_size) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(table_size);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      is_query_in  = is_query_ff;
      cmd          = '0;
      cmd.is_query = is_query_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ndq_pkg::ACT_QUERY) begin
                  cmd.start   = 1'b1;
                  cnt_in      = '0;
                  n_in        = n_sat;
                  is_query_in = 1'b1;
                  state_in    = ST_SCAN;
               end else begin
                  cmd.load    = 1'b1;
                  is_query_in = 1'b0;
                  state_in    = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff == n_ff) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.take = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         is_query_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         is_query_ff  <= is_query_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
   end

endmodule

/* rtl/core/ndq_datapath.sv */
`timescale 1ns / 1ps

module ndq_datapath #(
   parameter int TABLE_DEPTH     = 512,
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ndq_pkg::cmd_type                    cmd,
   input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] issue_addr,
   input  logic [ndq_pkg::IDX_W-1:0]           req_entry_index,
   input  logic signed [COMPONENT_WIDTH-1:0]   req_dir_x,
   input  logic signed [COMPONENT_WIDTH-1:0]   req_dir_y,
   input  logic signed [COMPONENT_WIDTH-1:0]   req_dir_z,
   input  logic signed [ndq_pkg::COS_W-1:0]    min_cosine,
   output ndq_pkg::status_type                 status,
   output logic [ndq_pkg::IDX_W-1:0]           rsp_best_index,
   output logic                                rsp_found
);

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW    = COMPONENT_WIDTH;
   localparam int DOT_W = 2 * CW + 2;
   localparam int CMP_W = (DOT_W > ndq_pkg::COS_W) ? DOT_W : ndq_pkg::COS_W;

   logic [3*CW-1:0]          mem [TABLE_DEPTH];
   logic [3*CW-1:0]          rd_data_ff;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;

   logic signed [CW-1:0]     qx_ff, qy_ff, qz_ff;
   logic signed [CW-1:0]     tx, ty, tz;
   logic signed [2*CW-1:0]   px_ff, py_ff, pz_ff;
   logic signed [CMP_W-1:0]  sum_in, sum_ff;
   logic signed [CMP_W-1:0]  best_ff;
   logic [AW-1:0]            best_idx_ff;
   logic                     hit_ff;
   logic                     v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]            idx1_ff, idx2_ff, idx3_ff;
   logic                     found_in;

   // Drop loads aimed beyond the table
   assign wr_en   = cmd.load & (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign wr_addr = AW'(req_entry_index);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {req_dir_x, req_dir_y, req_dir_z};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_data_ff <= mem[issue_addr];
      end
   end

   assign tx = rd_data_ff[3*CW-1:2*CW];
   assign ty = rd_data_ff[2*CW-1:CW];
   assign tz = rd_data_ff[CW-1:0];

   assign sum_in = CMP_W'(px_ff) + CMP_W'(py_ff) + CMP_W'(pz_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         qx_ff <= req_dir_x;
         qy_ff <= req_dir_y;
         qz_ff <= req_dir_z;
      end
      px_ff   <= tx * qx_ff;
      py_ff   <= ty * qy_ff;
      pz_ff   <= tz * qz_ff;
      sum_ff  <= sum_in;
      idx1_ff <= issue_addr;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Running best: strict compare keeps the lowest index on ties
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.start) begin
         hit_ff <= 1'b0;
      end else if (v3_ff && (sum_ff > best_ff)) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_ff     <= CMP_W'(min_cosine);
         best_idx_ff <= '0;
      end else if (v3_ff && (sum_ff > best_ff)) begin
         best_ff     <= sum_ff;
         best_idx_ff <= idx3_ff;
      end
   end

   assign status.busy = v1_ff | v2_ff | v3_ff;

   assign found_in = cmd.is_query & hit_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rsp_found      <= found_in;
         rsp_best_index <= found_in ? ndq_pkg::IDX_W'(best_idx_ff) : '0;
      end
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH       = 512;
   localparam int COMP_W      = 16;
   localparam int N_ROWS      = 20;
   localparam int N_PHASES    = 13;
   localparam int PHASE_ITEMS = 49;
   // Watchdog limit, sized for the slowest legal run: every item a full-depth
   // query behind the longest gap and stall.
   localparam int CYCLE_LIMIT = 4_000_000;

   // Direction components in Q2.14
   localparam logic [COMP_W-1:0] AXIS_POS  = 16'h4000;
   localparam logic [COMP_W-1:0] AXIS_NEG  = 16'hC000;
   localparam logic [COMP_W-1:0] COMP_MIN  = 16'h8000;
   localparam logic [COMP_W-1:0] COMP_MAX  = 16'h7FFF;
   localparam logic [COMP_W-1:0] COMP_ZERO = 16'h0000;

   // Cosine thresholds in Q2.28
   localparam logic [ndq_pkg::COS_W-1:0] COS_ZERO      = 30'h0000_0000;
   localparam logic [ndq_pkg::COS_W-1:0] COS_FLOOR     = 30'h2000_0000;
   localparam logic [ndq_pkg::COS_W-1:0] COS_CEIL      = 30'h1FFF_FFFF;
   localparam logic [ndq_pkg::COS_W-1:0] COS_ONE       = 30'h1000_0000;
   localparam logic [ndq_pkg::COS_W-1:0] COS_BELOW_ONE = 30'h0FFF_FFFF;
   localparam logic [ndq_pkg::COS_W-1:0] COS_NEG_ONE   = 30'h3000_0000;

   typedef struct packed {
      logic [COMP_W-1:0] x;
      logic [COMP_W-1:0] y;
      logic [COMP_W-1:0] z;
   } dir_type;

   typedef struct packed {
      logic [ndq_pkg::IDX_W-1:0] index;
      logic                      found;
   } match_type;

   // One directed transaction; when reconfig is set, drain and rewrite both
   // registers first. When known is set, the result column is the expectation.
   typedef struct packed {
      logic                       reconfig;
      logic [ndq_pkg::SIZE_W-1:0] size;
      logic [ndq_pkg::COS_W-1:0]  min_cos;
      logic                       action;
      logic [ndq_pkg::IDX_W-1:0]  slot;
      dir_type                    dir;
      logic                       known;
      match_type                  result;
   } stim_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_action = ndq_pkg::ACT_LOAD;
   logic [ndq_pkg::IDX_W-1:0]        req_entry_index = '0;
   logic signed [COMP_W-1:0]         req_dir_x = '0;
   logic signed [COMP_W-1:0]         req_dir_y = '0;
   logic signed [COMP_W-1:0]         req_dir_z = '0;
   logic                             rsp_stall = 1'b0;
   logic                             psel = 1'b0;
   logic                             penable = 1'b0;
   logic                             pwrite = 1'b0;
   logic [ndq_pkg::CSR_ADDR_W-1:0]   paddr = '0;
   logic [ndq_pkg::CSR_DATA_W-1:0]   pwdata = '0;
   wire                              req_stall;
   wire                              rsp_valid;
   wire  [ndq_pkg::IDX_W-1:0]        rsp_best_index;
   wire                              rsp_found;
   wire  [ndq_pkg::CSR_DATA_W-1:0]   prdata;
   wire                              pready;

   nearest_direction_quantizer #(
      .TABLE_DEPTH     (DEPTH),
      .COMPONENT_WIDTH (COMP_W)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_dir_z       (req_dir_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_best_index  (rsp_best_index),
      .rsp_found       (rsp_found),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // Shadow of the block: direction table and both registers
   dir_type                    dir_tab [DEPTH];
   logic [ndq_pkg::SIZE_W-1:0] size_reg = ndq_pkg::TABLE_SIZE_RESET;
   longint                     min_cos_reg = 0;
   match_type                  expected_matches [$];
   match_type                  head_match;
   int                         error_count = 0;
   bit                         gaps_on = 1'b1;
   int                         stall_left = 0;
   int                         free_left = 0;
   int                         stall_pick;

   // Preloaded table content stays within unit range, so the rows that
   // expect an exact axis hit below cannot be beaten by a preloaded entry.
   stim_row_type directed_rows [N_ROWS] = '{
      // loads answer 0 / 0
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_LOAD, 9'd0,
        '{AXIS_POS, COMP_ZERO, COMP_ZERO}, 1'b1, '{9'd0, 1'b0}},
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_LOAD, 9'd1,
        '{COMP_ZERO, AXIS_POS, COMP_ZERO}, 1'b1, '{9'd0, 1'b0}},
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_LOAD, 9'd2,
        '{COMP_ZERO, COMP_ZERO, AXIS_NEG}, 1'b1, '{9'd0, 1'b0}},
      // duplicate of slot 0: a tie must go to the lower index
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_LOAD, 9'd4,
        '{AXIS_POS, COMP_ZERO, COMP_ZERO}, 1'b1, '{9'd0, 1'b0}},
      // top slot, non-unit vector
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_LOAD, 9'd511,
        '{AXIS_NEG, AXIS_NEG, AXIS_NEG}, 1'b1, '{9'd0, 1'b0}},
      // reset registers: zero query never beats a zero threshold
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_QUERY, 9'd0,
        '{COMP_ZERO, COMP_ZERO, COMP_ZERO}, 1'b1, '{9'd0, 1'b0}},
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_QUERY, 9'd0,
        '{AXIS_POS, COMP_ZERO, COMP_ZERO}, 1'b0, '0},
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_QUERY, 9'd0,
        '{COMP_ZERO, AXIS_NEG, COMP_ZERO}, 1'b0, '0},
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_QUERY, 9'd0,
        '{COMP_MIN, COMP_MIN, COMP_MIN}, 1'b0, '0},
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_QUERY, 9'h1FF,
        '{COMP_MAX, COMP_MAX, COMP_MAX}, 1'b0, '0},
      // empty search
      '{1'b1, 10'd0, COS_ZERO, ndq_pkg::ACT_QUERY, 9'd0,
        '{AXIS_POS, COMP_ZERO, COMP_ZERO}, 1'b1, '{9'd0, 1'b0}},
      // lowest threshold: anything found in slot 0
      '{1'b1, 10'd1, COS_FLOOR, ndq_pkg::ACT_QUERY, 9'd0,
        '{COMP_ZERO, COMP_ZERO, COMP_ZERO}, 1'b1, '{9'd0, 1'b1}},
      // highest threshold out of reach of a unit dot product
      '{1'b1, 10'd1, COS_CEIL, ndq_pkg::ACT_QUERY, 9'd0,
        '{AXIS_POS, COMP_ZERO, COMP_ZERO}, 1'b1, '{9'd0, 1'b0}},
      // size beyond depth saturates; oversize query reaches the top slot
      '{1'b1, 10'h3FF, COS_CEIL, ndq_pkg::ACT_QUERY, 9'd0,
        '{COMP_MIN, COMP_MIN, COMP_MIN}, 1'b0, '0},
      // just under one: exact axis hits found, ties to the lower slot
      '{1'b1, 10'd512, COS_BELOW_ONE, ndq_pkg::ACT_QUERY, 9'd0,
        '{AXIS_POS, COMP_ZERO, COMP_ZERO}, 1'b1, '{9'd0, 1'b1}},
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_QUERY, 9'd0,
        '{COMP_ZERO, COMP_ZERO, AXIS_NEG}, 1'b1, '{9'd2, 1'b1}},
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_QUERY, 9'd0,
        '{COMP_ZERO, AXIS_POS, COMP_ZERO}, 1'b1, '{9'd1, 1'b1}},
      // threshold of exactly one: equal is not enough
      '{1'b1, 10'd512, COS_ONE, ndq_pkg::ACT_QUERY, 9'd0,
        '{AXIS_POS, COMP_ZERO, COMP_ZERO}, 1'b1, '{9'd0, 1'b0}},
      '{1'b1, 10'd1, COS_NEG_ONE, ndq_pkg::ACT_QUERY, 9'd0,
        '{AXIS_NEG, COMP_ZERO, COMP_ZERO}, 1'b1, '{9'd0, 1'b0}},
      '{1'b0, 10'd0, COS_ZERO, ndq_pkg::ACT_QUERY, 9'd0,
        '{COMP_ZERO, COMP_ZERO, COMP_ZERO}, 1'b1, '{9'd0, 1'b1}}
   };

   logic [ndq_pkg::SIZE_W-1:0] phase_sizes [N_PHASES] = '{
      10'd2, 10'd1, 10'd16, 10'd0, 10'd64, 10'h3FF, 10'd3,
      10'd512, 10'd500, 10'd7, 10'd130, 10'd1, 10'd33
   };

   initial begin
      forever #5 clock = ~clock;
   end

   // Search the shadow table: greatest dot product strictly above the
   // threshold, first slot wins on a tie.
   function automatic match_type predict_match(input dir_type q);
      match_type m;
      longint    best;
      longint    dot;
      int        n;
      m    = '0;
      best = min_cos_reg;
      n    = (size_reg > DEPTH) ? DEPTH : int'(size_reg);
      for (int k = 0; k < n; k++) begin
         dot = longint'($signed(dir_tab[k].x)) * longint'($signed(q.x))
             + longint'($signed(dir_tab[k].y)) * longint'($signed(q.y))
             + longint'($signed(dir_tab[k].z)) * longint'($signed(q.z));
         if (dot > best) begin
            best    = dot;
            m.index = ndq_pkg::IDX_W'(k);
            m.found = 1'b1;
         end
      end
      return m;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly unit-range components; wide ones use the full 16-bit span
   function automatic logic [COMP_W-1:0] rand_comp(input bit wide);
      if (wide) return COMP_W'($urandom);
      return COMP_W'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic dir_type rand_dir(input bit wide);
      dir_type           d;
      logic [COMP_W-1:0] s;
      if (!wide && $urandom_range(0, 6) == 0) begin
         d = '{COMP_ZERO, COMP_ZERO, COMP_ZERO};
         s = $urandom_range(0, 1) ? AXIS_POS : AXIS_NEG;
         case ($urandom_range(0, 2))
            0: d.x = s;
            1: d.y = s;
            default: d.z = s;
         endcase
      end else begin
         d.x = rand_comp(wide);
         d.y = rand_comp(wide);
         d.z = rand_comp(wide);
      end
      return d;
   endfunction

   // Small perturbation, saturated to the component width
   function automatic logic [COMP_W-1:0] nudge(input logic [COMP_W-1:0] c);
      int v;
      v = int'($signed(c)) + int'($urandom_range(0, 64)) - 32;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return COMP_W'(v);
   endfunction

   function automatic logic [ndq_pkg::COS_W-1:0] pick_threshold(input int phase);
      case (phase % 6)
         0: return COS_ZERO;
         1: return COS_FLOOR;
         2: return COS_CEIL;
         3: return ndq_pkg::COS_W'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
         4: return ndq_pkg::COS_W'($urandom);
         default: return ndq_pkg::COS_W'($urandom_range(200_000_000, 268_435_456));
      endcase
   endfunction

   // Drive one transaction, hold it until taken, then record the expected result
   task automatic push_item(input int gap, input logic action,
                            input logic [ndq_pkg::IDX_W-1:0] slot, input dir_type dir,
                            input logic known, input match_type known_result);
      match_type m;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= action;
      req_entry_index <= slot;
      req_dir_x       <= dir.x;
      req_dir_y       <= dir.y;
      req_dir_z       <= dir.z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // a 9-bit slot is always inside the table, so every load lands
      if (action == ndq_pkg::ACT_LOAD) begin
         dir_tab[slot] = dir;
         m = '0;
      end else begin
         m = predict_match(dir);
      end
      if (known) m = known_result;
      expected_matches = {expected_matches, m};
   endtask

   // Hold the sender until every outstanding result has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel,
                            input logic [ndq_pkg::CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [ndq_pkg::SIZE_W-1:0] size,
                            input logic [ndq_pkg::COS_W-1:0] min_cos);
      drain();
      csr_write(ndq_pkg::REG_TABLE_SIZE, ndq_pkg::CSR_DATA_W'(size));
      csr_write(ndq_pkg::REG_MIN_COSINE,
                {{(ndq_pkg::CSR_DATA_W - ndq_pkg::COS_W){min_cos[ndq_pkg::COS_W-1]}},
                 min_cos});
      size_reg    = size;
      min_cos_reg = longint'($signed(min_cos));
   endtask

   // Response side: check every accepted transaction against the oldest
   // expectation, and stall at random with short, long and stall-free runs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               $error("result with no transaction outstanding: best_index %0d found %0b",
                      rsp_best_index, rsp_found);
               error_count++;
            end else begin
               head_match = expected_matches.pop_front();
               if (rsp_best_index !== head_match.index) begin
                  $error("best_index: expected %0d, got %0d", head_match.index,
                         rsp_best_index);
                  error_count++;
               end
               if (rsp_found !== head_match.found) begin
                  $error("found: expected %0b, got %0b", head_match.found, rsp_found);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 45) free_left = $urandom_range(0, 6);
            else if (stall_pick < 75) stall_left = $urandom_range(1, 3);
            else if (stall_pick < 93) free_left = $urandom_range(30, 150);
            else stall_left = $urandom_range(15, 60);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      dir_type                   q;
      logic [ndq_pkg::IDX_W-1:0] slot;
      int                        n_eff;
      int                        k;
      int                        pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Preload every slot so no query can ever read an unwritten entry
      for (int s = 0; s < DEPTH; s++)
         push_item(pick_gap(), ndq_pkg::ACT_LOAD, ndq_pkg::IDX_W'(s), rand_dir(1'b0),
                   1'b0, '0);

      // Directed rows, starting from the reset register values
      for (int r = 0; r < N_ROWS; r++) begin
         if (directed_rows[r].reconfig)
            configure(directed_rows[r].size, directed_rows[r].min_cos);
         push_item(pick_gap(), directed_rows[r].action, directed_rows[r].slot,
                   directed_rows[r].dir, directed_rows[r].known, directed_rows[r].result);
      end

      // Random phases: one register setting each, every third one back to back
      for (int p = 0; p < N_PHASES; p++) begin
         configure(phase_sizes[p], pick_threshold(p));
         gaps_on = (p % 3 != 2);
         n_eff   = (size_reg == 0 || size_reg > DEPTH) ? DEPTH : int'(size_reg);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // now and then hold off until the block has emptied
            if ($urandom_range(0, 59) == 0) drain();
            if ($urandom_range(0, 99) < 60) begin
               // queries mostly aim at a searched entry, exact or nudged
               k    = $urandom_range(0, n_eff - 1);
               pick = $urandom_range(0, 9);
               if (pick < 3) q = dir_tab[k];
               else if (pick < 6) q = '{nudge(dir_tab[k].x), nudge(dir_tab[k].y),
                                        nudge(dir_tab[k].z)};
               else q = rand_dir(pick == 9);
               push_item(pick_gap(), ndq_pkg::ACT_QUERY, ndq_pkg::IDX_W'($urandom), q,
                         1'b0, '0);
            end else begin
               // at least half the loads land inside the searched range
               slot = $urandom_range(0, 1) ? ndq_pkg::IDX_W'($urandom_range(0, n_eff - 1))
                                           : ndq_pkg::IDX_W'($urandom);
               push_item(pick_gap(), ndq_pkg::ACT_LOAD, slot,
                         rand_dir($urandom_range(0, 9) == 0), 1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/ndq_pkg.sv
rtl/core/ndq_ctrl.sv
rtl/core/ndq_datapath.sv
rtl/core/nearest_direction_quantizer.sv
dv/tb_top.sv
